FILE: rtl/prq_pkg.sv
package prq_pkg;

  localparam int SLOTS = 64;
  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);

  localparam int ID_W    = 6;
  localparam int PRIO_W  = 16;
  localparam int STAMP_W = 32;
  localparam int SLICE_W = 8;
  localparam int QCNT_W  = 7;

  localparam logic [SLICE_W-1:0] MAX_SLICE_RST = 8'd5;

  typedef enum logic [1:0] {
    OP_ENQ  = 2'd0,
    OP_DEQ  = 2'd1,
    OP_PICK = 2'd2,
    OP_TICK = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_RD,
    S_EXEC,
    S_DONE
  } state_t;

  typedef struct packed {
    op_t                      op;
    logic [ID_W-1:0]          proc_id;
    logic signed [PRIO_W-1:0] priority_req;
  } in_item_t;

  typedef struct packed {
    logic               found;
    logic [ID_W-1:0]    chosen_id;
    logic               resched;
    logic               error;
    logic [QCNT_W-1:0]  queued_count;
    logic [SLICE_W-1:0] slice_left;
  } out_item_t;

  // Entry of the priority/stamp memory.
  typedef struct packed {
    logic signed [PRIO_W-1:0] prio;
    logic [STAMP_W-1:0]       stamp;
  } slot_rec_t;

endpackage

FILE: rtl/prq_ram.sv
module prq_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/prq_cmp.sv
module prq_cmp
  import prq_pkg::*;
(
  input  slot_rec_t                cand,
  input  logic [STAMP_W-1:0]       counter,
  input  logic signed [PRIO_W-1:0] best_prio,
  input  logic [STAMP_W-1:0]       best_age,
  output logic [STAMP_W-1:0]       cand_age,
  output logic                     better
);

  // Age is taken relative to the running counter so that stamp wrap is harmless.
  assign cand_age = counter - cand.stamp;
  assign better   = (cand.prio > best_prio) ||
                    ((cand.prio == best_prio) && (cand_age > best_age));

endmodule

FILE: rtl/priority_run_queue_scheduler.sv
// Enqueue, dequeue and tick: the result is registered after the read, execute and done states.
// Pick: the result is registered after the scan, drain, read, execute and done states;
//   one shared comparator scans one slot per cycle through the priority/stamp memory port.
// One item is in work at a time: no new transfer is taken before the result is loaded for output.
// Reset (rst_n low at a clock edge) empties the queue, zeroes every slice, the stamp counter
//   and the count, and sets max_slice to 5; there is no clearing pass.
module priority_run_queue_scheduler
  import prq_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  in_item_t           in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output out_item_t          out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [SLICE_W-1:0] cfg_data
);

  state_t state_r, state_nxt;

  // Latched command and configuration.
  in_item_t           cmd_r;
  logic [SLICE_W-1:0] max_slice_r;

  // Scheduler state. Queued marks and slice valid bits live in flops so that reset
  // clears them at once; an entry whose slice was never written reads as zero.
  logic [SLOTS-1:0]   queued_r;
  logic [SLOTS-1:0]   sl_vld_r;
  logic [STAMP_W-1:0] stamp_cnt_r;
  logic [CNT_W-1:0]   count_r;

  // Scan pipeline: stage one issues the memory read, stage two compares.
  logic [IDX_W-1:0]         scan_idx_r;
  logic                     cmp_vld_r;
  logic [IDX_W-1:0]         cmp_idx_r;
  logic                     have_r;
  logic [IDX_W-1:0]         best_idx_r;
  logic signed [PRIO_W-1:0] best_prio_r;
  logic [STAMP_W-1:0]       best_age_r;

  // Result staging and output register.
  out_item_t res_r;
  logic      out_valid_r;
  out_item_t out_data_r;

  // Memories.
  slot_rec_t          rec_q;
  slot_rec_t          rec_wdata;
  logic               rec_we;
  logic [SLICE_W-1:0] sl_q;
  logic [SLICE_W-1:0] sl_wdata;
  logic               sl_we;

  logic [IDX_W-1:0]   tgt_idx;
  logic               id_ok;
  logic [STAMP_W-1:0] cand_age;
  logic               better;
  logic [SLICE_W-1:0] cur_sl;
  logic               enq_ok;
  logic               deq_ok;
  logic               tick_ok;
  logic [SLICE_W-1:0] tick_sl;
  logic [SLICE_W-1:0] enq_sl;
  out_item_t          res_nxt;
  logic               in_xfer;
  logic               out_load;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_xfer   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Pick reads the slice of the winner; every other operation reads its own slot.
  assign tgt_idx = (cmd_r.op == OP_PICK) ? best_idx_r : IDX_W'(cmd_r.proc_id);
  assign id_ok   = (32'(cmd_r.proc_id) < SLOTS);

  prq_ram #(
    .W     ($bits(slot_rec_t)),
    .DEPTH (SLOTS)
  ) u_rec_ram (
    .clk   (clk),
    .we    (rec_we),
    .waddr (tgt_idx),
    .wdata (rec_wdata),
    .raddr (scan_idx_r),
    .rdata (rec_q)
  );

  prq_ram #(
    .W     (SLICE_W),
    .DEPTH (SLOTS)
  ) u_slice_ram (
    .clk   (clk),
    .we    (sl_we),
    .waddr (tgt_idx),
    .wdata (sl_wdata),
    .raddr (tgt_idx),
    .rdata (sl_q)
  );

  prq_cmp u_cmp (
    .cand      (rec_q),
    .counter   (stamp_cnt_r),
    .best_prio (best_prio_r),
    .best_age  (best_age_r),
    .cand_age  (cand_age),
    .better    (better)
  );

  // Operation decode in the execute state. The slice read was issued in the state before.
  always_comb begin
    cur_sl  = sl_vld_r[tgt_idx] ? sl_q : '0;
    enq_ok  = id_ok && !queued_r[tgt_idx];
    deq_ok  = id_ok && queued_r[tgt_idx];
    tick_ok = id_ok;
    tick_sl = (cur_sl != '0) ? cur_sl - 1'b1 : '0;
    enq_sl  = ((cur_sl == '0) || (cur_sl > max_slice_r)) ? max_slice_r : cur_sl;

    rec_wdata.prio  = cmd_r.priority_req;
    rec_wdata.stamp = stamp_cnt_r;
    rec_we   = 1'b0;
    sl_we    = 1'b0;
    sl_wdata = enq_sl;

    res_nxt              = '0;
    res_nxt.queued_count = QCNT_W'(count_r);

    unique case (cmd_r.op)
      OP_ENQ: begin
        res_nxt.error = !enq_ok;
        if (enq_ok) begin
          rec_we                = (state_r == S_EXEC);
          sl_we                 = (state_r == S_EXEC);
          res_nxt.queued_count  = QCNT_W'(count_r + 1'b1);
          res_nxt.slice_left    = enq_sl;
        end else if (id_ok) begin
          res_nxt.slice_left = cur_sl;
        end
      end
      OP_DEQ: begin
        res_nxt.error = !deq_ok;
        if (deq_ok) begin
          res_nxt.queued_count = QCNT_W'(count_r - 1'b1);
        end
        if (id_ok) begin
          res_nxt.slice_left = cur_sl;
        end
      end
      OP_PICK: begin
        if (have_r) begin
          res_nxt.found      = 1'b1;
          res_nxt.chosen_id  = ID_W'(best_idx_r);
          res_nxt.slice_left = cur_sl;
        end
      end
      OP_TICK: begin
        if (tick_ok) begin
          sl_we              = (state_r == S_EXEC);
          sl_wdata           = tick_sl;
          res_nxt.resched    = (tick_sl == '0);
          res_nxt.slice_left = tick_sl;
        end
      end
      default: ;
    endcase
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    out_load  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_data.op == OP_PICK) ? S_SCAN : S_RD;
        end
      end
      S_SCAN: begin
        if (scan_idx_r == IDX_W'(SLOTS - 1)) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: state_nxt = S_RD;
      S_RD:    state_nxt = S_EXEC;
      S_EXEC:  state_nxt = S_DONE;
      S_DONE: begin
        // Wait here while an earlier result is still held in the output register.
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      max_slice_r <= MAX_SLICE_RST;
      queued_r    <= '0;
      sl_vld_r    <= '0;
      stamp_cnt_r <= '0;
      count_r     <= '0;
      cmp_vld_r   <= 1'b0;
      have_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cmp_vld_r <= (state_r == S_SCAN);

      if (cfg_valid && cfg_ready) begin
        max_slice_r <= cfg_data;
      end

      if (in_xfer) begin
        have_r <= 1'b0;
      end else if (cmp_vld_r && queued_r[cmp_idx_r] && (!have_r || better)) begin
        have_r <= 1'b1;
      end

      if (state_r == S_EXEC) begin
        unique case (cmd_r.op)
          OP_ENQ: begin
            if (enq_ok) begin
              queued_r[tgt_idx] <= 1'b1;
              sl_vld_r[tgt_idx] <= 1'b1;
              stamp_cnt_r       <= stamp_cnt_r + 1'b1;
              count_r           <= count_r + 1'b1;
            end
          end
          OP_DEQ: begin
            if (deq_ok) begin
              queued_r[tgt_idx] <= 1'b0;
              count_r           <= count_r - 1'b1;
            end
          end
          OP_TICK: begin
            if (tick_ok) begin
              sl_vld_r[tgt_idx] <= 1'b1;
            end
          end
          OP_PICK: ;
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cmd_r      <= in_data;
      scan_idx_r <= '0;
    end else if (state_r == S_SCAN) begin
      scan_idx_r <= scan_idx_r + 1'b1;
    end
    cmp_idx_r <= scan_idx_r;

    // A later slot replaces the best only when strictly better, so ties keep the older entry.
    if (cmp_vld_r && queued_r[cmp_idx_r] && (!have_r || better)) begin
      best_idx_r  <= cmp_idx_r;
      best_prio_r <= rec_q.prio;
      best_age_r  <= cand_age;
    end

    if (state_r == S_EXEC) begin
      res_r <= res_nxt;
    end
    if (out_load) begin
      out_data_r <= res_r;
    end
  end

endmodule

FILE: rtl/prq_checker.sv
module prq_checker
  import prq_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input in_item_t           in_data,
  input logic               out_valid,
  input logic               out_ready,
  input out_item_t          out_data,
  input logic               cfg_valid,
  input logic               cfg_ready,
  input logic [SLICE_W-1:0] cfg_data
);

  // A held result stays put until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Only one item is in work, so ready drops right after an input transfer.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in work");

  a_found_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.found |-> out_data.queued_count != '0)
    else $error("pick found a slot with an empty queue");

  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.error |-> !out_data.found && !out_data.resched)
    else $error("error flagged together with a pick or tick flag");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.queued_count <= QCNT_W'(SLOTS))
    else $error("queued count above the number of slots");

endmodule

bind priority_run_queue_scheduler prq_checker u_prq_checker (.*);
